// File: design/clipmap_distance_field_sampler_assert.svh
// assertion macros for the clipmap sampler
`ifndef CLIPMAP_DISTANCE_FIELD_SAMPLER_ASSERT_SVH
`define CLIPMAP_DISTANCE_FIELD_SAMPLER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CDS_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("cds check failed");

// implication checked in the following cycle
`define CDS_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("cds check failed");

`endif

// File: design/cds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cds_pkg;
    localparam int unsigned POS_W   = 20;
    localparam int unsigned HALF_W  = 19;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned FRAC_W  = 12;
    localparam int unsigned CFG_W   = 60;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned REG_LEVELS = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF0   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF2   = 3'd5;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CHECK,
        ST_SETUP,
        ST_DIV,
        ST_AXIS,
        ST_READ,
        ST_LERP,
        ST_OUT
    } state_t;

    // shared divider control
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage
`default_nettype wire

// File: design/cds_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cds_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 17496
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: design/cds_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module cds_divider #(
    parameter int unsigned NUM_W = 40,
    parameter int unsigned DEN_W = 20
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output cds_pkg::div_ctl_t     ctl,
    output logic      [NUM_W-1:0] quot
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        if (start) begin
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quot      = quot_reg;
endmodule
`default_nettype wire

// File: design/clipmap_distance_field_sampler.sv
`timescale 1ns / 1ps
`default_nettype none
// clipmap distance field sampler
// input channel s_*: one beat is a command. command 0 writes voxel_value at
// (level, voxel_x, voxel_y, voxel_z) and gives no result; out-of-range
// writes are dropped. command 1 samples at (pos_x, pos_y, pos_z).
// result channel m_*: one beat per sample with distance, hit and level_used.
// a sample walks the levels one per cycle to find the first containing cube,
// then divides three grid coordinates on one shared restoring divider, reads
// the eight corners from the voxel ram, and runs the seven interpolations on
// one multiply unit, one per cycle after the last read returns.
// the time to a result is mostly set by the divider loop; a miss skips the
// divider and the voxel reads. the next beat is taken only after the result
// has been accepted. s_ready is low while a beat is in work or a result
// waits; a stalled m_ready holds the result in the output register.
// reset (aresetn, synchronous, active low) restores the level registers and
// the sequencer; voxel memory is not cleared and must be written before use.
// config writes use cfg_we/cfg_index/cfg_data; the user must make them only
// when the block is idle, as the block itself does not enforce this.
module clipmap_distance_field_sampler #(
    parameter int unsigned GRID_SIDE   = 18,
    parameter int unsigned LEVEL_COUNT = 3
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [59:0]           cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_command,
    input  wire logic [1:0]            s_level,
    input  wire logic [4:0]            s_voxel_x,
    input  wire logic [4:0]            s_voxel_y,
    input  wire logic [4:0]            s_voxel_z,
    input  wire logic signed [15:0]    s_voxel_value,
    input  wire logic signed [19:0]    s_pos_x,
    input  wire logic signed [19:0]    s_pos_y,
    input  wire logic signed [19:0]    s_pos_z,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [15:0]         m_distance,
    output logic                       m_hit,
    output logic [1:0]                 m_level_used
);
`include "clipmap_distance_field_sampler_assert.svh"

    localparam int unsigned DEPTH  = LEVEL_COUNT * GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned SRCH   = (LEVEL_COUNT < 3) ? LEVEL_COUNT : 3;
    localparam int unsigned TOP    = (GRID_SIDE - 1) * 4096;
    localparam int unsigned NUM_W  = 40;
    localparam int unsigned IDX_W  = 5;

    cds_pkg::state_t state_reg, state_next;

    logic [59:0] center_reg [3];
    logic [18:0] half_reg [3];

    // captured beat
    logic [1:0]         wlvl_reg;
    logic [4:0]         wx_reg, wy_reg, wz_reg;
    logic signed [15:0] wval_reg;
    logic signed [19:0] pos_reg [3];

    logic [1:0]  lvl_reg, lvl_next;
    logic [1:0]  axis_reg, axis_next;
    logic [2:0]  corner_reg, corner_next;
    logic [2:0]  step_reg, step_next;
    logic [IDX_W-1:0] i0_reg [3];
    logic [11:0] t_reg [3];
    logic signed [15:0] val_reg [8];
    logic        rd_pend_reg;
    logic [2:0]  rd_slot_reg;

    logic               m_valid_reg;
    logic signed [15:0] dist_reg;
    logic               hit_reg;
    logic [1:0]         lu_reg;

    // ---------------- containment test for current level ----------------
    logic signed [19:0] cax [3];
    logic               in_cube;
    logic signed [21:0] dif [3];
    logic [21:0]        adif [3];
    always_comb begin
        in_cube = 1'b1;
        for (int a = 0; a < 3; a++) begin
            cax[a]  = center_reg[lvl_reg][20*a +: 20];
            dif[a]  = 22'(pos_reg[a]) - 22'(cax[a]);
            adif[a] = dif[a][21] ? 22'(-dif[a]) : 22'(dif[a]);
            if (adif[a] > 22'(half_reg[lvl_reg])) in_cube = 1'b0;
        end
    end

    // ---------------- divider operands for current axis -----------------
    logic signed [22:0] num_s;
    logic [22:0]        num_c;
    logic [NUM_W-1:0]   div_num;
    logic [19:0]        div_den;
    logic               div_start;
    cds_pkg::div_ctl_t  div_ctl;
    logic [NUM_W-1:0]   div_q;
    logic [4:0]         gm1;
    always_comb begin
        num_s   = 23'(pos_reg[axis_reg]) - 23'(cax[axis_reg]) + 23'(half_reg[lvl_reg]);
        num_c   = num_s[22] ? '0 : num_s;
        gm1     = 5'(GRID_SIDE - 1);
        div_num = NUM_W'({num_c, 12'd0}) * NUM_W'(gm1);
        div_den = {half_reg[lvl_reg], 1'b0};
    end

    cds_divider #(.NUM_W(NUM_W), .DEN_W(20)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .numer(div_num), .denom(div_den), .ctl(div_ctl), .quot(div_q)
    );

    logic [NUM_W-1:0] g_clamp;
    always_comb begin
        if (half_reg[lvl_reg] == '0) g_clamp = '0;
        else if (div_q > NUM_W'(TOP)) g_clamp = NUM_W'(TOP);
        else g_clamp = div_q;
    end

    // ---------------- memory ----------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_rdata;
    logic [IDX_W-1:0]  cx, cy, cz;

    function automatic logic [IDX_W-1:0] up_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W:0] s;
        s = {1'b0, i} + 1'b1;
        return (s < (IDX_W+1)'(GRID_SIDE)) ? s[IDX_W-1:0] : IDX_W'(GRID_SIDE - 1);
    endfunction

    always_comb begin
        cx = corner_reg[0] ? up_idx(i0_reg[0]) : i0_reg[0];
        cy = corner_reg[1] ? up_idx(i0_reg[1]) : i0_reg[1];
        cz = corner_reg[2] ? up_idx(i0_reg[2]) : i0_reg[2];
        ram_raddr = ADDR_W'(((32'(lvl_reg) * GRID_SIDE + 32'(cz)) * GRID_SIDE
                    + 32'(cy)) * GRID_SIDE + 32'(cx));
        ram_waddr = ADDR_W'(((32'(wlvl_reg) * GRID_SIDE + 32'(wz_reg)) * GRID_SIDE
                    + 32'(wy_reg)) * GRID_SIDE + 32'(wx_reg));
        ram_we = (state_reg == cds_pkg::ST_WRITE) && (32'(wlvl_reg) < LEVEL_COUNT)
                 && (32'(wx_reg) < GRID_SIDE) && (32'(wy_reg) < GRID_SIDE)
                 && (32'(wz_reg) < GRID_SIDE);
    end

    cds_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(wval_reg),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // ---------------- shared interpolation unit ----------------
    // step 0..3 x lerps, 4..5 y lerps, 6 z lerp; results overwrite val slots
    logic signed [15:0] la, lb;
    logic [11:0]        lt;
    logic signed [30:0] lsum;
    logic signed [30:0] lrnd;
    logic signed [15:0] lres;
    logic [2:0]         lslot;
    always_comb begin
        unique case (step_reg)
            3'd0: begin la = val_reg[0]; lb = val_reg[1]; lt = t_reg[0]; lslot = 3'd0; end
            3'd1: begin la = val_reg[2]; lb = val_reg[3]; lt = t_reg[0]; lslot = 3'd1; end
            3'd2: begin la = val_reg[4]; lb = val_reg[5]; lt = t_reg[0]; lslot = 3'd2; end
            3'd3: begin la = val_reg[6]; lb = val_reg[7]; lt = t_reg[0]; lslot = 3'd3; end
            3'd4: begin la = val_reg[0]; lb = val_reg[1]; lt = t_reg[1]; lslot = 3'd0; end
            3'd5: begin la = val_reg[2]; lb = val_reg[3]; lt = t_reg[1]; lslot = 3'd1; end
            default: begin la = val_reg[0]; lb = val_reg[1]; lt = t_reg[2]; lslot = 3'd0; end
        endcase
        lsum = 31'(la) * $signed({1'b0, 14'(4096 - 32'(lt))})
             + 31'(lb) * $signed({1'b0, 14'(lt)});
        lrnd = lsum + 31'sd2048;
        lres = 16'(lrnd >>> 12);
    end

    // ---------------- sequencer ----------------
    logic s_acc, m_acc;
    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid_reg && m_ready;

    always_comb begin
        state_next  = state_reg;
        lvl_next    = lvl_reg;
        axis_next   = axis_reg;
        corner_next = corner_reg;
        step_next   = step_reg;
        div_start   = 1'b0;
        unique case (state_reg)
            cds_pkg::ST_IDLE: begin
                lvl_next = '0;
                if (s_acc) state_next = (s_command == cds_pkg::CMD_WRITE)
                                        ? cds_pkg::ST_WRITE : cds_pkg::ST_CHECK;
            end
            cds_pkg::ST_WRITE: state_next = cds_pkg::ST_IDLE;
            cds_pkg::ST_CHECK: begin
                if (in_cube) begin
                    state_next = cds_pkg::ST_SETUP;
                    axis_next  = '0;
                end else if (32'(lvl_reg) + 1 >= SRCH) begin
                    state_next = cds_pkg::ST_OUT;
                end else begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            cds_pkg::ST_SETUP: begin
                div_start  = 1'b1;
                state_next = cds_pkg::ST_DIV;
            end
            cds_pkg::ST_DIV: if (div_ctl.done) state_next = cds_pkg::ST_AXIS;
            cds_pkg::ST_AXIS: begin
                if (axis_reg == 2'd2) begin
                    state_next  = cds_pkg::ST_READ;
                    corner_next = '0;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = cds_pkg::ST_SETUP;
                end
            end
            cds_pkg::ST_READ: begin
                corner_next = corner_reg + 1'b1;
                if (corner_reg == 3'd7) state_next = cds_pkg::ST_LERP;
                step_next = '0;
            end
            cds_pkg::ST_LERP: begin
                if (!rd_pend_reg) begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == 3'd6) state_next = cds_pkg::ST_OUT;
                end
            end
            cds_pkg::ST_OUT: if (!m_valid_reg) state_next = cds_pkg::ST_IDLE;
            default: state_next = cds_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == cds_pkg::ST_IDLE) && !m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cds_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            half_reg[0] <= 19'd2048;
            half_reg[1] <= 19'd6144;
            half_reg[2] <= 19'd16384;
            lvl_reg <= '0;
        end else begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    cds_pkg::REG_CENTER0: center_reg[0] <= cfg_data;
                    cds_pkg::REG_CENTER1: center_reg[1] <= cfg_data;
                    cds_pkg::REG_CENTER2: center_reg[2] <= cfg_data;
                    cds_pkg::REG_HALF0:   half_reg[0] <= cfg_data[18:0];
                    cds_pkg::REG_HALF1:   half_reg[1] <= cfg_data[18:0];
                    cds_pkg::REG_HALF2:   half_reg[2] <= cfg_data[18:0];
                    default: ;
                endcase
            end
            rd_pend_reg <= (state_reg == cds_pkg::ST_READ);
            if (m_acc) m_valid_reg <= 1'b0;
            else if (state_reg == cds_pkg::ST_OUT && !m_valid_reg) m_valid_reg <= 1'b1;
        end
        axis_reg   <= axis_next;
        corner_reg <= corner_next;
        step_reg   <= step_next;
        rd_slot_reg <= corner_reg;
        if (s_acc) begin
            wlvl_reg <= s_level;
            wx_reg   <= s_voxel_x;
            wy_reg   <= s_voxel_y;
            wz_reg   <= s_voxel_z;
            wval_reg <= s_voxel_value;
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
            hit_reg  <= 1'b0;
            lu_reg   <= '0;
            dist_reg <= 16'sh7fff;
        end
        if (state_reg == cds_pkg::ST_CHECK && in_cube) begin
            hit_reg <= 1'b1;
            lu_reg  <= lvl_reg;
        end
        if (state_reg == cds_pkg::ST_AXIS) begin
            i0_reg[axis_reg] <= IDX_W'(g_clamp >> 12);
            t_reg[axis_reg]  <= g_clamp[11:0];
        end
        if (rd_pend_reg) val_reg[rd_slot_reg] <= ram_rdata;
        if (state_reg == cds_pkg::ST_LERP && !rd_pend_reg) begin
            val_reg[lslot] <= lres;
            if (step_reg == 3'd6) dist_reg <= lres;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_distance   = dist_reg;
    assign m_hit        = hit_reg;
    assign m_level_used = lu_reg;

    `CDS_ASSERT_IMP(a_busy_not_ready, aclk, aresetn,
        state_reg != cds_pkg::ST_IDLE, !s_ready)
    `CDS_ASSERT_NEXT(a_hold_result, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_distance) && $stable(m_hit))
    `CDS_ASSERT_IMP(a_miss_saturates, aclk, aresetn,
        m_valid && !m_hit, m_distance == 16'sh7fff && m_level_used == 2'd0)
endmodule
`default_nettype wire
